### src/fpa_pkg.sv
package fpa_pkg;

    localparam int FRACTION_BITS_DEFAULT = 10;
    localparam int IN_W  = 16;
    localparam int ANG_W = 9;
    localparam int MAG_W = 17;
    localparam logic [ANG_W-1:0] ANG_0   = 9'd0;
    localparam logic [ANG_W-1:0] ANG_45  = 9'd45;
    localparam logic [ANG_W-1:0] ANG_135 = 9'd135;
    localparam logic [ANG_W-1:0] ANG_180 = 9'd180;
    localparam logic [ANG_W-1:0] ANG_360 = 9'd360;

    // Sideband that travels alongside the quotient through the divider row
    typedef struct packed {
        logic             y_zero;
        logic             y_neg;
        logic             x_neg;
        logic             num_neg;
    } fpa_flags_t;

endpackage

### src/fpa_stream_if.sv
interface fpa_stream_if #(
    parameter int W = 16
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/fpa_div_cell.sv
// One restoring-division step: brings in one dividend bit, makes one quotient bit.
module fpa_div_cell #(
    parameter int NUM_W = 27,
    parameter int DEN_W = 17
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [DEN_W-1:0]     in_rem,
    input  logic [NUM_W-1:0]     in_num,
    input  logic [DEN_W-1:0]     in_den,
    input  fpa_pkg::fpa_flags_t  in_flags,
    output logic                 out_valid,
    output logic [DEN_W-1:0]     out_rem,
    output logic [NUM_W-1:0]     out_num,
    output logic [DEN_W-1:0]     out_den,
    output fpa_pkg::fpa_flags_t  out_flags
);
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;
    logic             valid_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    fpa_pkg::fpa_flags_t flags_reg;

    // shift in the top dividend bit and try to subtract
    always_comb
    begin
        trial = {in_rem, in_num[NUM_W-1]};
        diff  = trial - {1'b0, in_den};
        fits  = (trial >= {1'b0, in_den});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg   <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            num_reg   <= {in_num[NUM_W-2:0], fits};
            den_reg   <= in_den;
            flags_reg <= in_flags;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_flags = flags_reg;
endmodule

### src/fpa_poly.sv
// Polynomial tail: signed r, r^2, r^3, weighted sum, fold to degrees.
module fpa_poly #(
    parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEFAULT,
    localparam int Q_W = fpa_pkg::MAG_W + FRACTION_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [Q_W-1:0]                  in_quot,
    input  fpa_pkg::fpa_flags_t             in_flags,
    output logic                            out_valid,
    output logic [fpa_pkg::ANG_W-1:0]       out_angle
);
    // |r| <= 2^FB, so r fits FB+2 signed bits
    localparam int R_W  = FRACTION_BITS + 2;
    localparam int P_W  = 2 * R_W;
    localparam int S_W  = P_W + 8;

    // one valid bit per stage: r, r^2, r^3, sum, angle
    logic [4:0]             v_reg;
    fpa_pkg::fpa_flags_t    f1_reg, f2_reg, f3_reg, f4_reg;
    logic signed [R_W-1:0]  r1_reg, r2_reg, r3_reg;
    logic signed [P_W-1:0]  sq_reg, cu_reg;
    logic signed [S_W-1:0]  sum_reg;
    logic [fpa_pkg::ANG_W-1:0] ang_reg;

    logic signed [R_W-1:0]  r_next;
    logic signed [R_W-1:0]  sq_s;
    logic signed [P_W-1:0]  cu_p;
    logic signed [R_W-1:0]  cu_s;
    logic signed [S_W-1:0]  sum_next;
    logic signed [S_W-1:0]  sh;
    logic [fpa_pkg::ANG_W-1:0] base, ang, ang_next;

    always_comb
    begin
        r_next = in_flags.num_neg ? -$signed(in_quot[R_W-1:0]) : $signed(in_quot[R_W-1:0]);
        // floor shifts; values stay within R_W bits since |r| <= 1.0
        sq_s = R_W'(sq_reg >>> FRACTION_BITS);
        cu_p = sq_s * r2_reg;
        cu_s = R_W'(cu_reg >>> FRACTION_BITS);
        sum_next = S_W'(cu_s) * S_W'(11) - S_W'(r3_reg) * S_W'(56);
        sh   = sum_reg >>> FRACTION_BITS;
        base = f4_reg.x_neg ? fpa_pkg::ANG_135 : fpa_pkg::ANG_45;
        ang  = base + fpa_pkg::ANG_W'(sh);
        if (f4_reg.y_zero)
        begin
            ang_next = f4_reg.x_neg ? fpa_pkg::ANG_180 : fpa_pkg::ANG_0;
        end
        else if (f4_reg.y_neg)
        begin
            ang_next = fpa_pkg::ANG_360 - ang;
        end
        else
        begin
            ang_next = ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_reg  <= r_next;
            f1_reg  <= in_flags;
            sq_reg  <= r1_reg * r1_reg;
            r2_reg  <= r1_reg;
            f2_reg  <= f1_reg;
            cu_reg  <= cu_p;
            r3_reg  <= r2_reg;
            f3_reg  <= f2_reg;
            sum_reg <= sum_next;
            f4_reg  <= f3_reg;
            ang_reg <= ang_next;
        end
    end

    assign out_valid = v_reg[4];
    assign out_angle = ang_reg;
endmodule

### src/fixed_point_atan2_degrees.sv
// Path from request to result: one input stage, MAG_W+FRACTION_BITS divider cells,
// four polynomial stages and the output register.
// Throughput: one request per cycle while the output is not stalled; the divider is a row of restoring cells.
// Whole pipeline advances when the output register is free or being taken.
// Reset clears only valid bits; payload registers are not reset.
module fixed_point_atan2_degrees #(
    parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    fpa_stream_if.sink    in_req,
    fpa_stream_if.source  out_res
);
    localparam int MAG_W = fpa_pkg::MAG_W;
    localparam int NUM_W = MAG_W + FRACTION_BITS;
    localparam int STEPS = NUM_W;

    logic en;
    assign en = !out_res.valid || out_res.ready;
    assign in_req.ready = en;

    // input stage: saturate, magnitudes, numerator and divisor
    logic signed [fpa_pkg::IN_W-1:0] ys, xs;
    logic [MAG_W-1:0] ay, ax, num_mag, den;
    logic num_neg;
    fpa_pkg::fpa_flags_t flags;

    always_comb
    begin
        ys = $signed(in_req.data[31:16]);
        xs = $signed(in_req.data[15:0]);
        if (ys == 16'sh8000) ys = 16'sh8001;
        if (xs == 16'sh8000) xs = 16'sh8001;
        ay = ys[15] ? MAG_W'(-$signed({ys[15], ys})) : MAG_W'(ys);
        ax = xs[15] ? MAG_W'(-$signed({xs[15], xs})) : MAG_W'(xs);
        if (!xs[15])
        begin
            den     = ax + ay;
            num_neg = ax < ay;
            num_mag = num_neg ? ay - ax : ax - ay;
        end
        else
        begin
            den     = ay + ax;
            num_neg = ax > ay;
            num_mag = num_neg ? ax - ay : ay - ax;
        end
        flags.y_zero  = (ys == '0);
        flags.y_neg   = ys[15];
        flags.x_neg   = xs[15];
        flags.num_neg = num_neg;
        if (ys == '0)
        begin
            den = MAG_W'(1);
        end
    end

    logic                 v0_reg;
    logic [NUM_W-1:0]     n0_reg;
    logic [MAG_W-1:0]     d0_reg;
    fpa_pkg::fpa_flags_t  f0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n0_reg <= {num_mag, FRACTION_BITS'(0)};
            d0_reg <= den;
            f0_reg <= flags;
        end
    end

    // divider row
    logic                 cv [STEPS+1];
    logic [MAG_W-1:0]     cr [STEPS+1];
    logic [NUM_W-1:0]     cn [STEPS+1];
    logic [MAG_W-1:0]     cd [STEPS+1];
    fpa_pkg::fpa_flags_t  cf [STEPS+1];

    assign cv[0] = v0_reg;
    assign cr[0] = '0;
    assign cn[0] = n0_reg;
    assign cd[0] = d0_reg;
    assign cf[0] = f0_reg;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_div
        fpa_div_cell #(.NUM_W(NUM_W), .DEN_W(MAG_W)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (cv[i]),
            .in_rem    (cr[i]),
            .in_num    (cn[i]),
            .in_den    (cd[i]),
            .in_flags  (cf[i]),
            .out_valid (cv[i+1]),
            .out_rem   (cr[i+1]),
            .out_num   (cn[i+1]),
            .out_den   (cd[i+1]),
            .out_flags (cf[i+1])
        );
    end

    logic [fpa_pkg::ANG_W-1:0] angle;

    fpa_poly #(.FRACTION_BITS(FRACTION_BITS)) u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cv[STEPS]),
        .in_quot   (cn[STEPS]),
        .in_flags  (cf[STEPS]),
        .out_valid (out_res.valid),
        .out_angle (angle)
    );

    assign out_res.data = angle;
endmodule
